// ===== rtl/hrbd_pkg.sv =====
`default_nettype none

package hrbd_pkg;

  localparam int unsigned LENGTH_BITS = 32;

  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_BODY       = 3'd1,
    PH_SIZE       = 3'd2,
    PH_DATA       = 3'd3,
    PH_CHUNK_TAIL = 3'd4,
    PH_LAST_TAIL  = 3'd5,
    PH_DONE       = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_FRAMING = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_IGNORED = 2'd3
  } byte_kind_e;

  typedef enum logic [1:0] {
    LF_NOT_FOUND = 2'd0,
    LF_SKIP_WS   = 2'd1,
    LF_DIGITS    = 2'd2,
    LF_DONE      = 2'd3
  } len_field_e;

  typedef enum logic [1:0] {
    SL_LEAD_WS  = 2'd0,
    SL_ZERO     = 2'd1,
    SL_HEX      = 2'd2,
    SL_IGNORE   = 2'd3
  } size_line_e;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_C  = 8'h43;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;
  localparam logic [7:0] CHAR_UC_X  = 8'h58;

  localparam logic [3:0] KEY_LAST = 4'd14;

  typedef struct packed {
    logic [7:0] out_byte;
    byte_kind_e byte_kind;
    logic       message_end;
    logic       length_overflow;
  } result_t;

  // "Content-Length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  // bit 4 set when the byte is a hex digit, low bits give its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      r = {1'b1, b[3:0]};
    end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end else begin
      r = 5'b0_0000;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/http_response_body_deframer.sv =====
// each accepted byte's result is registered, in the skid register if the output stalls
// throughput: one byte per cycle while in_stall_o is low
// a two-entry output stage (result register plus skid register) lets a byte be taken
// while one result waits; in_stall_o rises only when both entries hold data
// reset (rst_ni low, asynchronous) returns the parser to the header phase and empties
// the output stage; a new response starts only after reset
`default_nettype none

module http_response_body_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      byte_kind_o,
  output logic            message_end_o,
  output logic            length_overflow_o
);

  localparam int unsigned LB = hrbd_pkg::LENGTH_BITS;

  hrbd_pkg::phase_e     phase_q, phase_d;
  logic                 nl_seen_q, nl_seen_d;
  logic                 cr_after_nl_q, cr_after_nl_d;
  logic [3:0]           match_pos_q, match_pos_d;
  hrbd_pkg::len_field_e lfs_q, lfs_d;
  hrbd_pkg::len_t       decl_len_q, decl_len_d;
  hrbd_pkg::size_line_e sls_q, sls_d;
  hrbd_pkg::len_t       bytes_rem_q, bytes_rem_d;

  hrbd_pkg::result_t    res;
  hrbd_pkg::result_t    out_q, out_d, skid_q, skid_d;
  logic                 out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic                 in_fire;
  logic [7:0]           b;
  logic                 is_lf, is_cr, is_dec;
  logic [4:0]           hexd;
  logic [3:0]           match_eff;
  logic                 key_hit;
  logic [4:0]           match_inc;
  logic [LB+3:0]        dec_wide;
  logic                 dec_ovf, dec_take;
  hrbd_pkg::len_t       dec_next;
  logic                 hex_ovf, hex_take, size_lf;
  hrbd_pkg::len_t       hex_next;
  hrbd_pkg::len_t       rem_dec;
  logic                 rem_last;
  logic                 hdr_lf_end;

  assign in_fire = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign b      = rx_byte_i;
  assign is_lf  = (b == hrbd_pkg::CHAR_LF);
  assign is_cr  = (b == hrbd_pkg::CHAR_CR);
  assign is_dec = (b >= hrbd_pkg::CHAR_ZERO) && (b <= hrbd_pkg::CHAR_NINE);
  assign hexd   = hrbd_pkg::hex_digit(b);

  // keyword matcher
  assign match_eff = (match_pos_q > hrbd_pkg::KEY_LAST) ? 4'd0 : match_pos_q;
  assign key_hit   = (b == hrbd_pkg::key_char(match_eff));
  assign match_inc = {1'b0, match_eff} + 5'd1;

  // decimal accumulate: v*10 + d, saturating
  assign dec_wide = {1'b0, decl_len_q, 3'b000} + {3'b000, decl_len_q, 1'b0}
                  + {{LB{1'b0}}, b[3:0]};
  assign dec_ovf  = |dec_wide[LB+3:LB];
  assign dec_next = dec_ovf ? '1 : dec_wide[LB-1:0];
  assign dec_take = ((lfs_q == hrbd_pkg::LF_SKIP_WS) || (lfs_q == hrbd_pkg::LF_DIGITS)) && is_dec;

  // hex accumulate: v*16 + h, saturating
  assign hex_ovf  = |bytes_rem_q[LB-1:LB-4];
  assign hex_next = hex_ovf ? '1 : {bytes_rem_q[LB-5:0], hexd[3:0]};
  assign size_lf  = is_lf && nl_seen_q;

  always_comb begin
    hex_take = 1'b0;
    unique case (sls_q)
      hrbd_pkg::SL_LEAD_WS: hex_take = hexd[4] && (b != hrbd_pkg::CHAR_ZERO);
      hrbd_pkg::SL_ZERO:    hex_take = hexd[4] && (b != hrbd_pkg::CHAR_LC_X)
                                       && (b != hrbd_pkg::CHAR_UC_X);
      hrbd_pkg::SL_HEX:     hex_take = hexd[4];
      default:              hex_take = 1'b0;
    endcase
    hex_take = hex_take && !size_lf;
  end

  assign rem_dec  = bytes_rem_q - LB'(bytes_rem_q != '0);
  assign rem_last = (rem_dec == '0);
  assign hdr_lf_end = is_lf && cr_after_nl_q;

  // next state
  always_comb begin
    phase_d       = phase_q;
    nl_seen_d     = nl_seen_q;
    cr_after_nl_d = cr_after_nl_q;
    match_pos_d   = match_pos_q;
    lfs_d         = lfs_q;
    decl_len_d    = decl_len_q;
    sls_d         = sls_q;
    bytes_rem_d   = bytes_rem_q;

    unique case (phase_q)
      hrbd_pkg::PH_HEADER: begin
        if (lfs_q == hrbd_pkg::LF_NOT_FOUND) begin
          if (key_hit) begin
            if (match_inc == 5'd15) begin
              lfs_d       = hrbd_pkg::LF_SKIP_WS;
              match_pos_d = 4'd0;
            end else begin
              match_pos_d = match_inc[3:0];
            end
          end else begin
            match_pos_d = (b == hrbd_pkg::CHAR_UC_C) ? 4'd1 : 4'd0;
          end
        end else if (lfs_q != hrbd_pkg::LF_DONE) begin
          if (is_dec) begin
            lfs_d      = hrbd_pkg::LF_DIGITS;
            decl_len_d = dec_next;
          end else if (!((lfs_q == hrbd_pkg::LF_SKIP_WS) && hrbd_pkg::is_space(b))) begin
            lfs_d = hrbd_pkg::LF_DONE;
          end
        end
        if (is_lf) begin
          if (cr_after_nl_q) begin
            nl_seen_d     = 1'b0;
            cr_after_nl_d = 1'b0;
            if (lfs_d != hrbd_pkg::LF_NOT_FOUND) begin
              if (decl_len_d == '0) begin
                phase_d = hrbd_pkg::PH_DONE;
              end else begin
                bytes_rem_d = decl_len_d;
                phase_d     = hrbd_pkg::PH_BODY;
              end
            end else begin
              sls_d       = hrbd_pkg::SL_LEAD_WS;
              bytes_rem_d = '0;
              phase_d     = hrbd_pkg::PH_SIZE;
            end
          end else begin
            nl_seen_d = 1'b1;
          end
        end else if (is_cr && nl_seen_q) begin
          cr_after_nl_d = 1'b1;
          nl_seen_d     = 1'b0;
        end else begin
          nl_seen_d     = 1'b0;
          cr_after_nl_d = 1'b0;
        end
      end
      hrbd_pkg::PH_BODY: begin
        bytes_rem_d = rem_dec;
        if (rem_last) begin
          phase_d = hrbd_pkg::PH_DONE;
        end
      end
      hrbd_pkg::PH_SIZE: begin
        if (size_lf) begin
          nl_seen_d     = 1'b0;
          cr_after_nl_d = 1'b0;
          phase_d = (bytes_rem_q == '0) ? hrbd_pkg::PH_LAST_TAIL : hrbd_pkg::PH_DATA;
        end else begin
          if (hex_take) begin
            bytes_rem_d = hex_next;
          end
          unique case (sls_q)
            hrbd_pkg::SL_LEAD_WS: begin
              if (b == hrbd_pkg::CHAR_ZERO) begin
                sls_d = hrbd_pkg::SL_ZERO;
              end else if (hexd[4]) begin
                sls_d = hrbd_pkg::SL_HEX;
              end else if (!hrbd_pkg::is_space(b)) begin
                sls_d = hrbd_pkg::SL_IGNORE;
              end
            end
            hrbd_pkg::SL_ZERO: begin
              if ((b == hrbd_pkg::CHAR_LC_X) || (b == hrbd_pkg::CHAR_UC_X) || hexd[4]) begin
                sls_d = hrbd_pkg::SL_HEX;
              end else begin
                sls_d = hrbd_pkg::SL_IGNORE;
              end
            end
            hrbd_pkg::SL_HEX: begin
              if (!hexd[4]) begin
                sls_d = hrbd_pkg::SL_IGNORE;
              end
            end
            default: sls_d = sls_q;
          endcase
          nl_seen_d = is_cr;
        end
      end
      hrbd_pkg::PH_DATA: begin
        bytes_rem_d = rem_dec;
        if (rem_last) begin
          cr_after_nl_d = 1'b0;
          phase_d       = hrbd_pkg::PH_CHUNK_TAIL;
        end
      end
      hrbd_pkg::PH_CHUNK_TAIL: begin
        if (cr_after_nl_q) begin
          cr_after_nl_d = 1'b0;
          nl_seen_d     = 1'b0;
          sls_d         = hrbd_pkg::SL_LEAD_WS;
          bytes_rem_d   = '0;
          phase_d       = hrbd_pkg::PH_SIZE;
        end else begin
          cr_after_nl_d = 1'b1;
        end
      end
      hrbd_pkg::PH_LAST_TAIL: begin
        if (cr_after_nl_q) begin
          cr_after_nl_d = 1'b0;
          phase_d       = hrbd_pkg::PH_DONE;
        end else begin
          cr_after_nl_d = 1'b1;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  // result of the current byte
  always_comb begin
    res.out_byte        = b;
    res.byte_kind       = hrbd_pkg::KIND_IGNORED;
    res.message_end     = 1'b0;
    res.length_overflow = 1'b0;
    unique case (phase_q)
      hrbd_pkg::PH_HEADER: begin
        res.byte_kind       = hrbd_pkg::KIND_HEADER;
        res.message_end     = hdr_lf_end && (lfs_d != hrbd_pkg::LF_NOT_FOUND)
                              && (decl_len_d == '0);
        res.length_overflow = dec_take && dec_ovf;
      end
      hrbd_pkg::PH_BODY: begin
        res.byte_kind   = hrbd_pkg::KIND_PAYLOAD;
        res.message_end = rem_last;
      end
      hrbd_pkg::PH_SIZE: begin
        res.byte_kind       = hrbd_pkg::KIND_FRAMING;
        res.length_overflow = hex_take && hex_ovf;
      end
      hrbd_pkg::PH_DATA: begin
        res.byte_kind = hrbd_pkg::KIND_PAYLOAD;
      end
      hrbd_pkg::PH_CHUNK_TAIL: begin
        res.byte_kind = hrbd_pkg::KIND_FRAMING;
      end
      hrbd_pkg::PH_LAST_TAIL: begin
        res.byte_kind   = hrbd_pkg::KIND_FRAMING;
        res.message_end = cr_after_nl_q;
      end
      default: res.byte_kind = hrbd_pkg::KIND_IGNORED;
    endcase
  end

  // output stage with skid register
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= hrbd_pkg::PH_HEADER;
      nl_seen_q     <= 1'b0;
      cr_after_nl_q <= 1'b0;
      match_pos_q   <= 4'd0;
      lfs_q         <= hrbd_pkg::LF_NOT_FOUND;
      decl_len_q    <= '0;
      sls_q         <= hrbd_pkg::SL_LEAD_WS;
      bytes_rem_q   <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q       <= phase_d;
        nl_seen_q     <= nl_seen_d;
        cr_after_nl_q <= cr_after_nl_d;
        match_pos_q   <= match_pos_d;
        lfs_q         <= lfs_d;
        decl_len_q    <= decl_len_d;
        sls_q         <= sls_d;
        bytes_rem_q   <= bytes_rem_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_q.out_byte;
  assign byte_kind_o       = out_q.byte_kind;
  assign message_end_o     = out_q.message_end;
  assign length_overflow_o = out_q.length_overflow;

endmodule

`default_nettype wire

// ===== test/http_response_body_deframer_tb.sv =====
`timescale 1ns / 1ps

class byte_tag_board;
  localparam int unsigned WIDE = hrbd_pkg::LENGTH_BITS + 5;

  hrbd_pkg::result_t    tags_due[$];
  int                   mismatches = 0;

  // mirror of the parser state
  hrbd_pkg::phase_e     phase      = hrbd_pkg::PH_HEADER;
  logic                 nl_seen    = 1'b0;
  logic                 cr_after   = 1'b0;
  logic [3:0]           key_pos    = 4'd0;
  hrbd_pkg::len_field_e len_state  = hrbd_pkg::LF_NOT_FOUND;
  hrbd_pkg::len_t       declared   = '0;
  hrbd_pkg::size_line_e line_state = hrbd_pkg::SL_LEAD_WS;
  hrbd_pkg::len_t       remaining  = '0;
  string                length_key = "Content-Length:";

  function bit blank(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function int hex_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return 16;
  endfunction

  // v = v * base + d, held at all ones when it no longer fits
  function bit grow(inout hrbd_pkg::len_t v, input int unsigned base, input int unsigned d);
    logic [WIDE-1:0] w;
    w = WIDE'(v);
    w = w * WIDE'(base) + WIDE'(d);
    if (w > WIDE'({hrbd_pkg::LENGTH_BITS{1'b1}})) begin
      v = '1;
      return 1'b1;
    end
    v = w[hrbd_pkg::LENGTH_BITS-1:0];
    return 1'b0;
  endfunction

  function void tag_request(logic [7:0] b);
    hrbd_pkg::result_t r;
    int                h;
    r.out_byte        = b;
    r.byte_kind       = hrbd_pkg::KIND_IGNORED;
    r.message_end     = 1'b0;
    r.length_overflow = 1'b0;
    case (phase)
      hrbd_pkg::PH_HEADER: begin
        r.byte_kind = hrbd_pkg::KIND_HEADER;
        if (len_state == hrbd_pkg::LF_NOT_FOUND) begin
          if (key_pos > hrbd_pkg::KEY_LAST) key_pos = 4'd0;
          if (b == length_key[key_pos]) begin
            key_pos++;
            if (key_pos == hrbd_pkg::KEY_LAST + 4'd1) begin
              len_state = hrbd_pkg::LF_SKIP_WS;
              key_pos   = 4'd0;
            end
          end else begin
            key_pos = (b == hrbd_pkg::CHAR_UC_C) ? 4'd1 : 4'd0;
          end
        end else if (len_state == hrbd_pkg::LF_SKIP_WS || len_state == hrbd_pkg::LF_DIGITS) begin
          if (b >= hrbd_pkg::CHAR_ZERO && b <= hrbd_pkg::CHAR_NINE) begin
            len_state = hrbd_pkg::LF_DIGITS;
            r.length_overflow = grow(declared, 10, 32'(b - hrbd_pkg::CHAR_ZERO));
          end else if (!(len_state == hrbd_pkg::LF_SKIP_WS && blank(b))) begin
            len_state = hrbd_pkg::LF_DONE;
          end
        end
        if (b == hrbd_pkg::CHAR_LF) begin
          if (cr_after) begin
            nl_seen  = 1'b0;
            cr_after = 1'b0;
            if (len_state != hrbd_pkg::LF_NOT_FOUND) begin
              if (declared == 0) begin
                r.message_end = 1'b1;
                phase = hrbd_pkg::PH_DONE;
              end else begin
                remaining = declared;
                phase = hrbd_pkg::PH_BODY;
              end
            end else begin
              line_state = hrbd_pkg::SL_LEAD_WS;
              remaining  = '0;
              phase      = hrbd_pkg::PH_SIZE;
            end
          end else begin
            nl_seen = 1'b1;
          end
        end else if (b == hrbd_pkg::CHAR_CR && nl_seen) begin
          cr_after = 1'b1;
          nl_seen  = 1'b0;
        end else begin
          nl_seen  = 1'b0;
          cr_after = 1'b0;
        end
      end
      hrbd_pkg::PH_BODY: begin
        r.byte_kind = hrbd_pkg::KIND_PAYLOAD;
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          r.message_end = 1'b1;
          phase = hrbd_pkg::PH_DONE;
        end
      end
      hrbd_pkg::PH_SIZE: begin
        r.byte_kind = hrbd_pkg::KIND_FRAMING;
        if (b == hrbd_pkg::CHAR_LF && nl_seen) begin
          nl_seen  = 1'b0;
          cr_after = 1'b0;
          phase = (remaining == 0) ? hrbd_pkg::PH_LAST_TAIL : hrbd_pkg::PH_DATA;
        end else begin
          h = hex_of(b);
          case (line_state)
            hrbd_pkg::SL_LEAD_WS: begin
              if (b == hrbd_pkg::CHAR_ZERO) begin
                line_state = hrbd_pkg::SL_ZERO;
              end else if (h < 16) begin
                r.length_overflow = grow(remaining, 16, h);
                line_state = hrbd_pkg::SL_HEX;
              end else if (!blank(b)) begin
                line_state = hrbd_pkg::SL_IGNORE;
              end
            end
            hrbd_pkg::SL_ZERO: begin
              if (b == hrbd_pkg::CHAR_LC_X || b == hrbd_pkg::CHAR_UC_X) begin
                line_state = hrbd_pkg::SL_HEX;
              end else if (h < 16) begin
                r.length_overflow = grow(remaining, 16, h);
                line_state = hrbd_pkg::SL_HEX;
              end else begin
                line_state = hrbd_pkg::SL_IGNORE;
              end
            end
            hrbd_pkg::SL_HEX: begin
              if (h < 16) r.length_overflow = grow(remaining, 16, h);
              else line_state = hrbd_pkg::SL_IGNORE;
            end
            default: ;
          endcase
          nl_seen = (b == hrbd_pkg::CHAR_CR);
        end
      end
      hrbd_pkg::PH_DATA: begin
        r.byte_kind = hrbd_pkg::KIND_PAYLOAD;
        if (remaining != 0) remaining--;
        if (remaining == 0) begin
          cr_after = 1'b0;
          phase = hrbd_pkg::PH_CHUNK_TAIL;
        end
      end
      hrbd_pkg::PH_CHUNK_TAIL: begin
        r.byte_kind = hrbd_pkg::KIND_FRAMING;
        if (cr_after) begin
          cr_after   = 1'b0;
          nl_seen    = 1'b0;
          line_state = hrbd_pkg::SL_LEAD_WS;
          remaining  = '0;
          phase      = hrbd_pkg::PH_SIZE;
        end else begin
          cr_after = 1'b1;
        end
      end
      hrbd_pkg::PH_LAST_TAIL: begin
        r.byte_kind = hrbd_pkg::KIND_FRAMING;
        if (cr_after) begin
          cr_after = 1'b0;
          r.message_end = 1'b1;
          phase = hrbd_pkg::PH_DONE;
        end else begin
          cr_after = 1'b1;
        end
      end
      default: r.byte_kind = hrbd_pkg::KIND_IGNORED;
    endcase
    tags_due = {tags_due, r};
  endfunction

  function void check_tag(logic [7:0] ob, logic [1:0] kind, logic fin, logic ovf);
    hrbd_pkg::result_t e;
    if (tags_due.size() == 0) begin
      $error("result with no request waiting: out_byte %0h", ob);
      mismatches++;
      return;
    end
    e = tags_due.pop_front();
    if (ob !== e.out_byte) begin
      $error("out_byte expected %0h actual %0h", e.out_byte, ob);
      mismatches++;
    end
    if (kind !== e.byte_kind) begin
      $error("byte_kind expected %0d actual %0d", e.byte_kind, kind);
      mismatches++;
    end
    if (fin !== e.message_end) begin
      $error("message_end expected %0b actual %0b", e.message_end, fin);
      mismatches++;
    end
    if (ovf !== e.length_overflow) begin
      $error("length_overflow expected %0b actual %0b", e.length_overflow, ovf);
      mismatches++;
    end
  endfunction
endclass

module http_response_body_deframer_tb;

  localparam int ITEMS = 1000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] byte_kind_o;
  logic       message_end_o;
  logic       length_overflow_o;

  byte_tag_board board = new();
  logic [7:0]    resp_q[$];

  http_response_body_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_kind_o      (byte_kind_o),
    .message_end_o    (message_end_o),
    .length_overflow_o(length_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.tag_request(rx_byte_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_tag(out_byte_o, byte_kind_o, message_end_o, length_overflow_o);
    end
  end

  task automatic put_byte(input logic [7:0] v);
    resp_q = {resp_q, v};
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  task automatic add_random(input int n, input int lo, input int hi);
    repeat (n) put_byte(8'($urandom_range(hi, lo)));
  endtask

  // white space without CR or LF
  task automatic add_blank();
    logic [7:0] ws[4] = '{8'h20, 8'h09, 8'h0B, 8'h0C};
    repeat ($urandom_range(0, 3)) put_byte(ws[$urandom_range(0, 3)]);
  endtask

  task automatic build_response();
    int    mode;
    int    n;
    int    ending;
    string s;
    add_text("HTTP/1.1 200 OK\r\n");
    // near misses of the length key: doubled first letter, cut short, wrong case
    add_text("CContent-Lengt: 7\r\ncontent-length: 9\n");
    put_byte(8'h00);
    put_byte(8'hFF);
    add_text("\r\n");
    repeat ($urandom_range(0, 3)) begin
      add_text("X-");
      add_random($urandom_range(1, 20), 8'h20, 8'h7E);
      add_text("\r\n");
    end
    mode = $urandom_range(0, 3);
    if (mode == 0) begin
      n = 0;
      add_text("Content-Length:");
      // line break inside the white space before the number
      if ($urandom_range(0, 3) == 0) add_text("\r\n ");
      add_blank();
      case ($urandom_range(0, 7))
        4: add_text("0");
        5: begin
          if ($urandom_range(0, 1) == 1) begin
            add_text("-12");
          end else begin
            n = $urandom_range(1, 50);
            add_text($sformatf("%0d+3", n));
          end
        end
        6: begin
          add_text("99999999999999999999");
          n = ITEMS;
        end
        7: add_text("\r\nX-Y: 1");
        default: begin
          n = $urandom_range(1, ITEMS);
          if ($urandom_range(0, 1) == 1) add_text("00");
          add_text($sformatf("%0d", n));
          if ($urandom_range(0, 1) == 1) add_text(" ok");
        end
      endcase
      add_text("\r\n\r\n");
      add_random(n, 0, 255);
    end else begin
      add_text("\r\n");
      while (resp_q.size() < ITEMS - 40) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 32);
        if ($urandom_range(0, 3) == 0) add_blank();
        case ($urandom_range(0, 4))
          1: add_text("0x");
          2: add_text("0X");
          3: add_text("0");
          default: ;
        endcase
        s = $sformatf("%0h", n);
        add_text($urandom_range(0, 1) ? s.toupper() : s);
        if ($urandom_range(0, 2) == 0) begin
          add_text(";");
          add_random($urandom_range(0, 8), 8'h20, 8'h7E);
          // lone CR and lone LF inside the extension do not end the line
          if ($urandom_range(0, 1) == 1) add_text("\rq\n");
        end
        add_text("\r\n");
        add_random(n, 0, 255);
        if ($urandom_range(0, 3) == 0) add_random(2, 0, 255);
        else add_text("\r\n");
      end
      ending = $urandom_range(0, 7);
      if (ending == 0) begin
        // size wider than the length register: data never runs out
        add_text($sformatf("%0h%08h%08h\r\n", $urandom_range(1, 15), $urandom, $urandom));
        add_random(40, 0, 255);
      end else begin
        case (ending)
          1: add_text("0\r\n");
          2: add_text("000\r\n");
          3: add_text("0x\r\n");
          4: add_text("\r\n");
          5: add_text(" ;end\r\n");
          6: add_text("zz\r\n");
          default: add_text("0X;last\r\n");
        endcase
        if ($urandom_range(0, 1) == 1) add_text("\r\n");
        else add_random(2, 0, 255);
      end
    end
    // bytes after the end of the message, enough to keep the run near full length
    add_random(20, 0, 255);
    while (resp_q.size() < ITEMS) add_random(1, 0, 255);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (board.tags_due.size() != 0) @(posedge clk_i);
  endtask

  // receiver: segments of different stall patterns, one long hold-off
  initial begin
    int cycles;
    int mode;
    int seg;
    bit held;
    cycles = 0;
    held   = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && cycles >= 150) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (80) begin
          @(posedge clk_i);
          cycles++;
        end
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(4, 60);
      repeat (seg) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 0);
          2:       out_stall_i <= ($urandom_range(0, 4) == 0);
          default: out_stall_i <= (cycles % 3 == 0);
        endcase
        @(posedge clk_i);
        cycles++;
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int half;
    build_response();
    half = resp_q.size() / 2;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sent = 0;
    while (sent < resp_q.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < resp_q.size(); k++) begin
        send_byte(resp_q[sent]);
        sent++;
        if (sent == half) begin
          // let every outstanding request come out before going on
          in_valid_i <= 1'b0;
          wait_drained();
        end
      end
      if (sent < resp_q.size()) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.tags_due.size() != 0) begin
      $error("%0d results never arrived", board.tags_due.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
